// ===== hw/rtl/utcl_pkg.sv =====
`default_nettype none

package utcl_pkg;

	localparam int unsigned BASE_YEAR  = 1970;
	localparam int unsigned MONTH_DAYS = 31;

	localparam logic [11:0] YEAR_BASE    = 12'd1970;
	localparam logic [11:0] YEAR_NOLEAP  = 12'd2100;
	localparam logic [11:0] YEAR_BLK_SHT = 12'd2098;
	localparam logic [2:0]  JAN1_WD_BASE = 3'd4;

	localparam logic [32:0] SECS_YEAR      = 33'd31536000;
	localparam logic [32:0] SECS_LEAP_YEAR = 33'd31622400;
	localparam logic [32:0] SECS_BLK       = 33'd126230400;
	localparam logic [32:0] SECS_BLK_SHORT = 33'd126144000;
	localparam logic [31:0] SECS_HOUR      = 32'd3600;

	localparam logic [2:0] REG_ZONE_OFFSET  = 3'd0;
	localparam logic [2:0] REG_BEGIN_MONTH  = 3'd1;
	localparam logic [2:0] REG_BEGIN_HOUR   = 3'd2;
	localparam logic [2:0] REG_END_MONTH    = 3'd3;
	localparam logic [2:0] REG_END_HOUR     = 3'd4;

	typedef struct packed {
		logic [4:0] zone_offset_hours;
		logic [3:0] summer_begin_month;
		logic [4:0] summer_begin_hour;
		logic [3:0] summer_end_month;
		logic [4:0] summer_end_hour;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic day;
		logic sec;
		logic sel_end;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic epoch_zero;
	} sts_t;

	function automatic logic [3:0] clamp_month(input logic [3:0] m);
		logic [3:0] r;
		r = m;
		if (m == 4'd0) begin
			r = 4'd1;
		end else if (m > 4'd12) begin
			r = 4'd12;
		end
		return r;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// (days_before + 30) mod 7
	function automatic logic [2:0] wd_offset(input logic [3:0] m);
		logic [2:0] r;
		case (m)
			4'd1:    r = 3'd2;
			4'd2:    r = 3'd5;
			4'd3:    r = 3'd5;
			4'd4:    r = 3'd1;
			4'd5:    r = 3'd3;
			4'd6:    r = 3'd6;
			4'd7:    r = 3'd1;
			4'd8:    r = 3'd4;
			4'd9:    r = 3'd0;
			4'd10:   r = 3'd2;
			4'd11:   r = 3'd5;
			4'd12:   r = 3'd0;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utcl_cfg_regs.sv =====
`default_nettype none

module utcl_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [4:0]    cfg_data,
	output utcl_pkg::cfg_t     cfg
);

	utcl_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zone_offset_hours  <= 5'd0;
			cfg_q.summer_begin_month <= 4'd3;
			cfg_q.summer_begin_hour  <= 5'd1;
			cfg_q.summer_end_month   <= 4'd10;
			cfg_q.summer_end_hour    <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				utcl_pkg::REG_ZONE_OFFSET: cfg_q.zone_offset_hours  <= cfg_data;
				utcl_pkg::REG_BEGIN_MONTH: cfg_q.summer_begin_month <= cfg_data[3:0];
				utcl_pkg::REG_BEGIN_HOUR:  cfg_q.summer_begin_hour  <= cfg_data;
				utcl_pkg::REG_END_MONTH:   cfg_q.summer_end_month   <= cfg_data[3:0];
				utcl_pkg::REG_END_HOUR:    cfg_q.summer_end_hour    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utcl_ctrl.sv =====
`default_nettype none

module utcl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire utcl_pkg::sts_t sts,
	output utcl_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		IDLE,
		SEARCH,
		BEG_DAY,
		BEG_SEC,
		END_DAY,
		END_SEC,
		FINISH
	} state_t;

	state_t state_q;

	assign busy = (state_q != IDLE);

	always_comb begin
		cmd         = '0;
		cmd.load    = start && (state_q == IDLE);
		cmd.step    = (state_q == SEARCH) && !sts.search_done && !sts.epoch_zero;
		cmd.day     = (state_q == BEG_DAY) || (state_q == END_DAY);
		cmd.sec     = (state_q == BEG_SEC) || (state_q == END_SEC);
		cmd.sel_end = (state_q == END_DAY) || (state_q == END_SEC);
		cmd.finish  = (state_q == FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= SEARCH;
					end
				end
				SEARCH: begin
					if (sts.epoch_zero) begin
						state_q <= FINISH;
					end else if (sts.search_done) begin
						state_q <= BEG_DAY;
					end
				end
				BEG_DAY: state_q <= BEG_SEC;
				BEG_SEC: state_q <= END_DAY;
				END_DAY: state_q <= END_SEC;
				END_SEC: state_q <= FINISH;
				FINISH:  state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utcl_dpath.sv =====
`default_nettype none

module utcl_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   epoch_utc,
	input  wire utcl_pkg::cfg_t cfg,
	input  wire utcl_pkg::cmd_t cmd,
	output utcl_pkg::sts_t     sts,
	output logic               done,
	output logic [31:0]        local_seconds,
	output logic               summer_active,
	output logic               failed
);

	logic [31:0] epoch_q;
	logic [11:0] year_q;
	logic [31:0] ystart_q;
	logic [15:0] ydays_q;
	logic [2:0]  jan1_wd_q;
	logic [16:0] day_q;
	logic [33:0] t_begin_q;
	logic [33:0] t_end_q;
	logic        done_q;
	logic [31:0] local_q;
	logic        summer_q;
	logic        failed_q;

	// year search
	logic        leap_y;
	logic        blk_short;
	logic [32:0] end1;
	logic [32:0] end4;
	logic        jump1;
	logic        jump4;
	logic [3:0]  wd_inc;
	logic [3:0]  wd_sum;
	logic [2:0]  jan1_next;

	// boundary
	logic [3:0]  sel_month;
	logic [4:0]  sel_hour;
	logic [3:0]  mi;
	logic        leap_adj;
	logic [16:0] d_full;
	logic [3:0]  bwd_sum;
	logic [2:0]  bwd;
	logic [21:0] hrs;
	logic [33:0] t_sec;

	// result
	logic        summer;
	logic signed [17:0] zone_ext;
	logic signed [17:0] zone_secs;
	logic [31:0] zone_add;
	logic [31:0] local_sum;

	assign leap_y    = (year_q[1:0] == 2'd0) && (year_q != utcl_pkg::YEAR_NOLEAP);
	assign blk_short = (year_q == utcl_pkg::YEAR_BLK_SHT);
	assign end1 = {1'b0, ystart_q} +
		(leap_y ? utcl_pkg::SECS_LEAP_YEAR : utcl_pkg::SECS_YEAR);
	assign end4 = {1'b0, ystart_q} +
		(blk_short ? utcl_pkg::SECS_BLK_SHORT : utcl_pkg::SECS_BLK);
	assign jump4 = (year_q[1:0] == 2'd2) && ({1'b0, epoch_q} >= end4);
	assign jump1 = !jump4 && ({1'b0, epoch_q} >= end1);

	always_comb begin
		if (jump4) begin
			wd_inc = blk_short ? 4'd4 : 4'd5;
		end else begin
			wd_inc = leap_y ? 4'd2 : 4'd1;
		end
	end

	assign wd_sum    = {1'b0, jan1_wd_q} + wd_inc;
	assign jan1_next = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

	assign sts.search_done = !(jump4 || jump1);
	assign sts.epoch_zero  = (epoch_q == 32'd0);

	assign sel_month = cmd.sel_end ? cfg.summer_end_month : cfg.summer_begin_month;
	assign sel_hour  = cmd.sel_end ? cfg.summer_end_hour  : cfg.summer_begin_hour;
	assign mi        = utcl_pkg::clamp_month(sel_month);
	assign leap_adj  = (mi > 4'd2) && leap_y;
	assign d_full    = {1'b0, ydays_q} + 17'(utcl_pkg::days_before(mi)) +
		17'(leap_adj) + 17'(utcl_pkg::MONTH_DAYS - 1);
	assign bwd_sum   = {1'b0, jan1_wd_q} + {1'b0, utcl_pkg::wd_offset(mi)} + 4'(leap_adj);
	assign bwd       = (bwd_sum >= 4'd7) ? 3'(bwd_sum - 4'd7) : bwd_sum[2:0];

	assign hrs   = 22'(day_q) * 22'd24 + 22'(sel_hour);
	assign t_sec = 34'(hrs) * 34'd3600;

	assign summer = ({2'b00, epoch_q} >= t_begin_q) && ({2'b00, epoch_q} < t_end_q);

	assign zone_ext  = {{13{cfg.zone_offset_hours[4]}}, cfg.zone_offset_hours};
	assign zone_secs = zone_ext * 18'sd3600;
	assign zone_add  = {{14{zone_secs[17]}}, zone_secs};
	assign local_sum = epoch_q + (summer ? utcl_pkg::SECS_HOUR : 32'd0) + zone_add;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			epoch_q   <= epoch_utc;
			year_q    <= utcl_pkg::YEAR_BASE;
			ystart_q  <= 32'd0;
			ydays_q   <= 16'd0;
			jan1_wd_q <= utcl_pkg::JAN1_WD_BASE;
		end else if (cmd.step) begin
			jan1_wd_q <= jan1_next;
			if (jump4) begin
				year_q   <= year_q + 12'd4;
				ystart_q <= end4[31:0];
				ydays_q  <= ydays_q + (blk_short ? 16'd1460 : 16'd1461);
			end else if (jump1) begin
				year_q   <= year_q + 12'd1;
				ystart_q <= end1[31:0];
				ydays_q  <= ydays_q + (leap_y ? 16'd366 : 16'd365);
			end
		end
		if (cmd.day) begin
			day_q <= d_full - 17'(bwd);
		end
		if (cmd.sec) begin
			if (cmd.sel_end) begin
				t_end_q <= t_sec;
			end else begin
				t_begin_q <= t_sec;
			end
		end
		if (cmd.finish) begin
			failed_q <= sts.epoch_zero;
			summer_q <= summer && !sts.epoch_zero;
			local_q  <= sts.epoch_zero ? 32'd0 : local_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done          = done_q;
	assign local_seconds = local_q;
	assign summer_active = summer_q;
	assign failed        = failed_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utc_to_local_time_with_eu_dst_top.sv =====
// channel   signals                               transfer
// --------  ------------------------------------  ---------------------------------
// input     start, busy, epoch_utc                start high while busy low
// result    done, local_seconds, summer_active,   done high, one cycle
//           failed
// config    cfg_valid, cfg_ready, cfg_index,      cfg_valid and cfg_ready high
//           cfg_data
//
// the year search steps four years or one year per cycle from 1970,
// then each summer boundary passes a day state and a seconds state,
// begin before end, and a finish state registers the result
// a zero epoch leaves the search at once and goes to the finish state
// reset restores the default zone and summer rules
// done cannot be held off; busy is low in the cycle done is shown
`default_nettype none

module utc_to_local_time_with_eu_dst_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] epoch_utc,
	output logic             done,
	output logic [31:0]      local_seconds,
	output logic             summer_active,
	output logic             failed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);

	utcl_pkg::cfg_t cfg;
	utcl_pkg::cmd_t cmd;
	utcl_pkg::sts_t sts;

	utcl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	utcl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	utcl_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.epoch_utc     (epoch_utc),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.done          (done),
		.local_seconds (local_seconds),
		.summer_active (summer_active),
		.failed        (failed)
	);

endmodule

`default_nettype wire
